/* rtl/core/rws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rws_pkg
// shared constants and stage payload types of the wall slice setup pipeline
// ---------------------------------------------------------------------------
package rws_pkg;

   localparam int SCREEN_HEIGHT = 512;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
   // cell size in map units, a power of two
   localparam int CELL_SCALE    = 64;
   // bits of a q16.16 position below one cell
   localparam int CELL_SH       = $clog2(CELL_SCALE) + 16;
   // cell_scale * screen_height in q16.16, numerator of the line height
   localparam logic [47:0] LH_NUM = 48'((64'(CELL_SCALE) * 64'(SCREEN_HEIGHT)) << 16);
   localparam logic [31:0] MAX32  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      FACE_NORTH = 2'd0,
      FACE_SOUTH = 2'd1,
      FACE_EAST  = 2'd2,
      FACE_WEST  = 2'd3
   } face_type;

   localparam logic [2:0] CSR_NORTH_W = 3'd0;
   localparam logic [2:0] CSR_NORTH_H = 3'd1;
   localparam logic [2:0] CSR_SOUTH_W = 3'd2;
   localparam logic [2:0] CSR_SOUTH_H = 3'd3;
   localparam logic [2:0] CSR_EAST_W  = 3'd4;
   localparam logic [2:0] CSR_EAST_H  = 3'd5;
   localparam logic [2:0] CSR_WEST_W  = 3'd6;
   localparam logic [2:0] CSR_WEST_H  = 3'd7;

   // side data carried beside the distance divider
   typedef struct packed {
      logic signed [18:0]  odir;
      logic [CELL_SH-1:0]  opos;
      face_type            face;
      logic                mir;
      logic [10:0]         w;
      logic [10:0]         h;
      logic                dir0;
      logic                dzero;
      logic                ovf;
   } p1_type;

   // side data carried beside the line height divider
   typedef struct packed {
      logic [31:0] wall_dist;
      logic        lhsat;
      face_type    face;
      logic [10:0] col;
      logic [10:0] h;
   } p2_type;

   // side data carried beside the texture step divider
   typedef struct packed {
      logic [31:0] wall_dist;
      logic [15:0] lh;
      logic [8:0]  ds;
      logic [8:0]  de;
      logic [14:0] term;
      face_type    face;
      logic [10:0] col;
   } p3_type;

endpackage
`default_nettype wire

/* rtl/core/rws_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rws_div
// pipelined restoring divider, one quotient bit per stage, with side payload
// ---------------------------------------------------------------------------
module rws_div #(
   parameter int Q_W = 32,
   parameter int D_W = 19,
   parameter int P_W = 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [D_W-1:0] in_rem,   // upper numerator bits, below in_den
   input  wire logic [Q_W-1:0] in_low,   // lower numerator bits
   input  wire logic [D_W-1:0] in_den,
   input  wire logic [P_W-1:0] in_pay,
   output logic                out_valid,
   output logic [Q_W-1:0]      out_quo,
   output logic [P_W-1:0]      out_pay
);

   logic [D_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0] sh_ff  [Q_W];
   logic [D_W-1:0] den_ff [Q_W];
   logic [P_W-1:0] pay_ff [Q_W];
   logic           vld_ff [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      logic [D_W-1:0] rem_src;
      logic [Q_W-1:0] sh_src;
      logic [D_W-1:0] den_src;
      logic [P_W-1:0] pay_src;
      logic           vld_src;
      logic [D_W:0]   rem_w;
      logic [D_W:0]   diff;
      logic           ge;
      logic [D_W-1:0] rem_in;
      logic [Q_W-1:0] sh_in;

      if (i == 0) begin : g_first
         assign rem_src = in_rem;
         assign sh_src  = in_low;
         assign den_src = in_den;
         assign pay_src = in_pay;
         assign vld_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign sh_src  = sh_ff[i-1];
         assign den_src = den_ff[i-1];
         assign pay_src = pay_ff[i-1];
         assign vld_src = vld_ff[i-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign rem_w  = {rem_src, sh_src[Q_W-1]};
      assign diff   = rem_w - {1'b0, den_src};
      assign ge     = (rem_w >= {1'b0, den_src});
      assign rem_in = ge ? diff[D_W-1:0] : rem_w[D_W-1:0];
      assign sh_in  = {sh_src[Q_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            sh_ff[i]  <= sh_in;
            den_ff[i] <= den_src;
            pay_ff[i] <= pay_src;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quo   = sh_ff[Q_W-1];
   assign out_pay   = pay_ff[Q_W-1];

endmodule
`default_nettype wire

/* rtl/core/raycast_wall_slice_setup_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// raycast_wall_slice_setup_top
// turns one ray hit into the wall slice draw and texture setup of a column
// ---------------------------------------------------------------------------
// usage
// - req channel: one ray hit per transfer (side in tuser, cell, signs,
//   direction and player position in tdata)
// - rsp channel: one slice setup per transfer, in request order
// - csr port: texture sizes of the four faces, written while idle
// - throughput: one hit per cycle; the whole pipeline advances as one,
//   so an item enters every cycle while the result side takes transfers
// - pipeline: the three bit-serial dividers (32 + 16 + 27 stages) plus
//   11 setup stages lie between req transfer and rsp valid
// - reset clears all valid bits and sets every texture size to 64
// - when the receiver stalls, every stage holds; req_tready drops in the
//   same cycle, nothing is lost or repeated
// - a stalled result waits in the output register, and every stage behind
//   it holds with it, bubbles included
// ---------------------------------------------------------------------------
module raycast_wall_slice_setup_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // ray hit input
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cell_x, cell_y, sign_x, sign_y, dir_x, dir_y, player_x, player_y
   input  wire logic [127:0] req_tdata,
   // hit_side
   input  wire logic         req_tuser,
   // slice setup output
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // wall_dist, line_height, draw_start, draw_end, face_texture,
   // tex_column, tex_step, tex_start
   output logic [143:0]      rsp_tdata,
   // texture size registers
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [10:0]  csr_wdata
);

   localparam int CS = rws_pkg::CELL_SH;

   // global advance: the output register is empty or being taken
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ------------------------------------------------------------------
   // texture size registers
   // ------------------------------------------------------------------
   logic [10:0] nw_ff, nh_ff, sw_ff, sh_ff, ew_ff, eh_ff, ww_ff, wh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nw_ff <= 11'd64; nh_ff <= 11'd64;
         sw_ff <= 11'd64; sh_ff <= 11'd64;
         ew_ff <= 11'd64; eh_ff <= 11'd64;
         ww_ff <= 11'd64; wh_ff <= 11'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            rws_pkg::CSR_NORTH_W: nw_ff <= csr_wdata;
            rws_pkg::CSR_NORTH_H: nh_ff <= csr_wdata;
            rws_pkg::CSR_SOUTH_W: sw_ff <= csr_wdata;
            rws_pkg::CSR_SOUTH_H: sh_ff <= csr_wdata;
            rws_pkg::CSR_EAST_W:  ew_ff <= csr_wdata;
            rws_pkg::CSR_EAST_H:  eh_ff <= csr_wdata;
            rws_pkg::CSR_WEST_W:  ww_ff <= csr_wdata;
            rws_pkg::CSR_WEST_H:  wh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage a: pick the axis, form the signed distance numerator
   // ------------------------------------------------------------------
   logic               in_side;
   logic [9:0]         in_cx, in_cy;
   logic [1:0]         in_sx, in_sy;
   logic signed [18:0] in_dx, in_dy;
   logic [31:0]        in_px, in_py;

   assign in_side = req_tuser;
   assign in_cx   = req_tdata[9:0];
   assign in_cy   = req_tdata[19:10];
   assign in_sx   = req_tdata[21:20];
   assign in_sy   = req_tdata[23:22];
   assign in_dx   = req_tdata[42:24];
   assign in_dy   = req_tdata[61:43];
   assign in_px   = req_tdata[93:62];
   assign in_py   = req_tdata[125:94];

   logic signed [33:0] a_num_in;
   logic signed [18:0] a_dir_in, a_odir_in;
   logic [CS-1:0]      a_opos_in;
   rws_pkg::face_type  a_face_in;
   logic               a_mir_in;
   logic [10:0]        a_w_in, a_h_in;

   always_comb begin
      if (!in_side) begin
         // vertical grid line: x terms, one cell more when stepping left
         a_num_in  = $signed({8'd0, in_cx, 16'd0}) - $signed({2'd0, in_px})
                   + (in_sx[1] ? 34'sh10000 : 34'sh0);
         a_dir_in  = in_dx;
         a_odir_in = in_dy;
         a_opos_in = in_py[CS-1:0];
         a_face_in = (in_dx > 0) ? rws_pkg::FACE_WEST : rws_pkg::FACE_EAST;
         a_mir_in  = (in_dx < 0);
      end else begin
         a_num_in  = $signed({8'd0, in_cy, 16'd0}) - $signed({2'd0, in_py})
                   + (in_sy[1] ? 34'sh10000 : 34'sh0);
         a_dir_in  = in_dy;
         a_odir_in = in_dx;
         a_opos_in = in_px[CS-1:0];
         a_face_in = (in_dy > 0) ? rws_pkg::FACE_NORTH : rws_pkg::FACE_SOUTH;
         a_mir_in  = (in_dy > 0);
      end
      unique case (a_face_in)
         rws_pkg::FACE_NORTH: begin a_w_in = nw_ff; a_h_in = nh_ff; end
         rws_pkg::FACE_SOUTH: begin a_w_in = sw_ff; a_h_in = sh_ff; end
         rws_pkg::FACE_EAST:  begin a_w_in = ew_ff; a_h_in = eh_ff; end
         rws_pkg::FACE_WEST:  begin a_w_in = ww_ff; a_h_in = wh_ff; end
         default:             begin a_w_in = nw_ff; a_h_in = nh_ff; end
      endcase
   end

   logic               a_v_ff;
   logic signed [33:0] a_num_ff;
   logic signed [18:0] a_dir_ff, a_odir_ff;
   logic [CS-1:0]      a_opos_ff;
   rws_pkg::face_type  a_face_ff;
   logic               a_mir_ff;
   logic [10:0]        a_w_ff, a_h_ff;

   // ------------------------------------------------------------------
   // stage b: magnitudes, sign of the quotient, overflow check
   // ------------------------------------------------------------------
   logic [33:0]     b_anum_in;
   logic [18:0]     b_adir_in;
   rws_pkg::p1_type b_pay_in;

   assign b_anum_in = a_num_ff[33] ? 34'(-a_num_ff) : 34'(a_num_ff);
   assign b_adir_in = a_dir_ff[18] ? 19'(-a_dir_ff) : 19'(a_dir_ff);

   always_comb begin
      b_pay_in.odir  = a_odir_ff;
      b_pay_in.opos  = a_opos_ff;
      b_pay_in.face  = a_face_ff;
      b_pay_in.mir   = a_mir_ff;
      b_pay_in.w     = a_w_ff;
      b_pay_in.h     = a_h_ff;
      b_pay_in.dir0  = (a_dir_ff == 19'sd0);
      // quotient negative or zero numerator: distance is 0
      b_pay_in.dzero = (a_num_ff == 34'sd0) || (a_num_ff[33] != a_dir_ff[18]);
      // quotient at or above 2^32 saturates
      b_pay_in.ovf   = ({1'b0, b_anum_in} >= {b_adir_in, 16'd0});
   end

   logic            b_v_ff;
   logic [32:0]     b_anum_ff;
   logic [18:0]     b_adir_ff;
   rws_pkg::p1_type b_pay_ff;

   // distance divider: (|num| << 16) / |dir|
   logic            d1_v;
   logic [31:0]     d1_q;
   rws_pkg::p1_type d1_pay;

   rws_div #(
      .Q_W(32),
      .D_W(19),
      .P_W($bits(rws_pkg::p1_type))
   ) u_div_dist (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_v_ff),
      .in_rem   ({2'd0, b_anum_ff[32:16]}),
      .in_low   ({b_anum_ff[15:0], 16'd0}),
      .in_den   (b_adir_ff),
      .in_pay   (b_pay_ff),
      .out_valid(d1_v),
      .out_quo  (d1_q),
      .out_pay  (d1_pay)
   );

   // ------------------------------------------------------------------
   // stage c: distance with its special cases
   // ------------------------------------------------------------------
   logic [31:0] c_dist_in;

   always_comb begin
      priority if (d1_pay.dir0)  c_dist_in = rws_pkg::MAX32;
      else if (d1_pay.dzero)     c_dist_in = 32'd0;
      else if (d1_pay.ovf)       c_dist_in = rws_pkg::MAX32;
      else                       c_dist_in = d1_q;
   end

   logic               c_v_ff;
   logic [31:0]        c_dist_ff;
   logic signed [18:0] c_odir_ff;
   logic [CS-1:0]      c_opos_ff;
   rws_pkg::face_type  c_face_ff;
   logic               c_mir_ff;
   logic [10:0]        c_w_ff, c_h_ff;

   // ------------------------------------------------------------------
   // stage d: distance times the other direction, line height overflow
   // ------------------------------------------------------------------
   logic signed [51:0] d_prod_in;
   logic               d_lhsat_in;

   assign d_prod_in  = $signed({1'b0, c_dist_ff}) * c_odir_ff;
   assign d_lhsat_in = (c_dist_ff == 32'd0) || ({c_dist_ff, 16'd0} <= rws_pkg::LH_NUM);

   logic               d_v_ff;
   logic signed [51:0] d_prod_ff;
   logic               d_lhsat_ff;
   logic [31:0]        d_dist_ff;
   logic [CS-1:0]      d_opos_ff;
   rws_pkg::face_type  d_face_ff;
   logic               d_mir_ff;
   logic [10:0]        d_w_ff, d_h_ff;

   // ------------------------------------------------------------------
   // stage e: wall hit coordinate modulo one cell (floor by arithmetic shift)
   // ------------------------------------------------------------------
   logic [CS-1:0] e_hit_in;
   assign e_hit_in = d_opos_ff + d_prod_ff[CS+15:16];

   logic              e_v_ff;
   logic [CS-1:0]     e_hit_ff;
   logic              e_lhsat_ff;
   logic [31:0]       e_dist_ff;
   rws_pkg::face_type e_face_ff;
   logic              e_mir_ff;
   logic [10:0]       e_w_ff, e_h_ff;

   // ------------------------------------------------------------------
   // stage f: scale the cell fraction by the texture width
   // ------------------------------------------------------------------
   logic [CS+10:0] f_cprod_in;
   assign f_cprod_in = e_hit_ff * e_w_ff;

   logic              f_v_ff;
   logic [CS+10:0]    f_cprod_ff;
   logic              f_lhsat_ff;
   logic [31:0]       f_dist_ff;
   rws_pkg::face_type f_face_ff;
   logic              f_mir_ff;
   logic [10:0]       f_w_ff, f_h_ff;

   // ------------------------------------------------------------------
   // stage g: texture column, mirrored on the flipped faces
   // ------------------------------------------------------------------
   logic [10:0]     g_col_raw;
   rws_pkg::p2_type g_pay_in;

   assign g_col_raw = f_cprod_ff[CS+10:CS];

   always_comb begin
      g_pay_in.wall_dist = f_dist_ff;
      g_pay_in.lhsat     = f_lhsat_ff;
      g_pay_in.face      = f_face_ff;
      g_pay_in.h         = f_h_ff;
      priority if (f_w_ff == 11'd0) g_pay_in.col = 11'd0;
      else if (f_mir_ff)            g_pay_in.col = f_w_ff - g_col_raw - 11'd1;
      else                          g_pay_in.col = g_col_raw;
   end

   logic            g_v_ff;
   rws_pkg::p2_type g_pay_ff;

   // line height divider: LH_NUM / dist, only the low 16 quotient bits
   logic            d2_v;
   logic [15:0]     d2_q;
   rws_pkg::p2_type d2_pay;

   rws_div #(
      .Q_W(16),
      .D_W(32),
      .P_W($bits(rws_pkg::p2_type))
   ) u_div_lh (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (g_v_ff),
      .in_rem   (rws_pkg::LH_NUM[47:16]),
      .in_low   (rws_pkg::LH_NUM[15:0]),
      .in_den   (g_pay_ff.wall_dist),
      .in_pay   (g_pay_ff),
      .out_valid(d2_v),
      .out_quo  (d2_q),
      .out_pay  (d2_pay)
   );

   // ------------------------------------------------------------------
   // stage h: line height and clamped draw limits
   // ------------------------------------------------------------------
   logic [15:0]     h_lh;
   logic [14:0]     h_half_lh;
   logic [15:0]     h_sum;
   rws_pkg::p3_type h_pay_in;

   assign h_lh      = d2_pay.lhsat ? 16'hFFFF : d2_q;
   assign h_half_lh = h_lh[15:1];
   assign h_sum     = {1'b0, h_half_lh} + 16'(rws_pkg::HALF_HEIGHT);

   always_comb begin
      h_pay_in.wall_dist = d2_pay.wall_dist;
      h_pay_in.lh        = h_lh;
      h_pay_in.face      = d2_pay.face;
      h_pay_in.col       = d2_pay.col;
      if ({1'b0, h_half_lh} >= 16'(rws_pkg::HALF_HEIGHT)) begin
         h_pay_in.ds = 9'd0;
      end else begin
         h_pay_in.ds = 9'(16'(rws_pkg::HALF_HEIGHT) - {1'b0, h_half_lh});
      end
      if (h_sum >= 16'(rws_pkg::SCREEN_HEIGHT)) begin
         h_pay_in.de = 9'(rws_pkg::SCREEN_HEIGHT - 1);
      end else begin
         h_pay_in.de = h_sum[8:0];
      end
      // rows clipped off the top of the screen
      if ({1'b0, h_half_lh} > 16'(rws_pkg::HALF_HEIGHT)) begin
         h_pay_in.term = 15'({1'b0, h_half_lh} - 16'(rws_pkg::HALF_HEIGHT));
      end else begin
         h_pay_in.term = 15'd0;
      end
   end

   logic            h_v_ff;
   rws_pkg::p3_type h_pay_ff;
   logic [10:0]     h_h_ff;

   // texture step divider: (h << 16) / line height
   logic            d3_v;
   logic [26:0]     d3_q;
   rws_pkg::p3_type d3_pay;

   rws_div #(
      .Q_W(27),
      .D_W(16),
      .P_W($bits(rws_pkg::p3_type))
   ) u_div_step (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (h_v_ff),
      .in_rem   (16'd0),
      .in_low   ({h_h_ff, 16'd0}),
      .in_den   (h_pay_ff.lh),
      .in_pay   (h_pay_ff),
      .out_valid(d3_v),
      .out_quo  (d3_q),
      .out_pay  (d3_pay)
   );

   // ------------------------------------------------------------------
   // stage i: texture step, saturated on a zero line height
   // ------------------------------------------------------------------
   logic [31:0]     i_step_in;
   assign i_step_in = (d3_pay.lh == 16'd0) ? rws_pkg::MAX32 : {5'd0, d3_q};

   logic            i_v_ff;
   logic [31:0]     i_step_ff;
   rws_pkg::p3_type i_pay_ff;

   // ------------------------------------------------------------------
   // stage j: start position product
   // ------------------------------------------------------------------
   logic [46:0]     j_prod_in;
   assign j_prod_in = i_pay_ff.term * i_step_ff;

   logic            j_v_ff;
   logic [46:0]     j_prod_ff;
   logic [31:0]     j_step_ff;
   rws_pkg::p3_type j_pay_ff;

   // ------------------------------------------------------------------
   // stage k: saturate and pack into the output register
   // ------------------------------------------------------------------
   logic [31:0]  k_start;
   logic [143:0] k_data_in;

   assign k_start = (j_prod_ff[46:32] != 15'd0) ? rws_pkg::MAX32 : j_prod_ff[31:0];

   always_comb begin
      k_data_in          = '0;
      k_data_in[31:0]    = j_pay_ff.wall_dist;
      k_data_in[47:32]   = j_pay_ff.lh;
      k_data_in[56:48]   = j_pay_ff.ds;
      k_data_in[65:57]   = j_pay_ff.de;
      k_data_in[67:66]   = j_pay_ff.face;
      k_data_in[77:68]   = j_pay_ff.col[9:0];
      k_data_in[109:78]  = j_step_ff;
      k_data_in[141:110] = k_start;
   end

   logic         k_v_ff;
   logic [143:0] k_data_ff;

   // ------------------------------------------------------------------
   // stage registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
         k_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= d1_v;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= d2_v;
         i_v_ff <= d3_v;
         j_v_ff <= i_v_ff;
         k_v_ff <= j_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_num_ff   <= a_num_in;
         a_dir_ff   <= a_dir_in;
         a_odir_ff  <= a_odir_in;
         a_opos_ff  <= a_opos_in;
         a_face_ff  <= a_face_in;
         a_mir_ff   <= a_mir_in;
         a_w_ff     <= a_w_in;
         a_h_ff     <= a_h_in;

         b_anum_ff  <= b_anum_in[32:0];
         b_adir_ff  <= b_adir_in;
         b_pay_ff   <= b_pay_in;

         c_dist_ff  <= c_dist_in;
         c_odir_ff  <= d1_pay.odir;
         c_opos_ff  <= d1_pay.opos;
         c_face_ff  <= d1_pay.face;
         c_mir_ff   <= d1_pay.mir;
         c_w_ff     <= d1_pay.w;
         c_h_ff     <= d1_pay.h;

         d_prod_ff  <= d_prod_in;
         d_lhsat_ff <= d_lhsat_in;
         d_dist_ff  <= c_dist_ff;
         d_opos_ff  <= c_opos_ff;
         d_face_ff  <= c_face_ff;
         d_mir_ff   <= c_mir_ff;
         d_w_ff     <= c_w_ff;
         d_h_ff     <= c_h_ff;

         e_hit_ff   <= e_hit_in;
         e_lhsat_ff <= d_lhsat_ff;
         e_dist_ff  <= d_dist_ff;
         e_face_ff  <= d_face_ff;
         e_mir_ff   <= d_mir_ff;
         e_w_ff     <= d_w_ff;
         e_h_ff     <= d_h_ff;

         f_cprod_ff <= f_cprod_in;
         f_lhsat_ff <= e_lhsat_ff;
         f_dist_ff  <= e_dist_ff;
         f_face_ff  <= e_face_ff;
         f_mir_ff   <= e_mir_ff;
         f_w_ff     <= e_w_ff;
         f_h_ff     <= e_h_ff;

         g_pay_ff   <= g_pay_in;

         h_pay_ff   <= h_pay_in;
         h_h_ff     <= d2_pay.h;

         i_step_ff  <= i_step_in;
         i_pay_ff   <= d3_pay;

         j_prod_ff  <= j_prod_in;
         j_step_ff  <= i_step_ff;
         j_pay_ff   <= i_pay_ff;

         k_data_ff  <= k_data_in;
      end
   end

   assign rsp_tvalid = k_v_ff;
   assign rsp_tdata  = k_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_zero_dist_tall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[31:0] == 32'd0) |-> (rsp_tdata[47:32] == 16'hFFFF))
      else $error("zero distance without saturated line height");

   a_draw_order : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[56:48] <= rsp_tdata[65:57]))
      else $error("draw start below draw end");

   a_zero_lh_step : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[47:32] == 16'd0) |-> (rsp_tdata[109:78] == rws_pkg::MAX32))
      else $error("zero line height without saturated step");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (i_v_ff && !en) |=> (i_v_ff && $stable(i_step_ff)))
      else $error("pipeline stage moved during a stall");

endmodule
`default_nettype wire
